// ===== rtl/mpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mpc_pkg
// Shared constants, register indexes and the command and status bundles that
// pass between the colouriser's controller and its datapath.
// ----------------------------------------------------------------------------
package mpc_pkg;

    // Default sizing of the pixel indexes and of the round counter.
    localparam int COORD_BITS_DEF = 12;
    localparam int ITER_BITS_DEF  = 10;

    // Configuration port.
    localparam int CFG_W       = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int MAX_ITER_W  = 10;
    localparam int ESC_W       = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_RE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_IM = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_RE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_STEP_IM  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ITER = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESC_RSQ  = 3'd5;

    localparam logic signed [CFG_W-1:0] START_RE_RST = -32'sd536870912;
    localparam logic signed [CFG_W-1:0] START_IM_RST = -32'sd402653184;
    localparam logic signed [CFG_W-1:0] STEP_RE_RST  = 32'sd1677722;
    localparam logic signed [CFG_W-1:0] STEP_IM_RST  = 32'sd1677722;
    localparam logic [MAX_ITER_W-1:0]   MAX_ITER_RST = 10'd64;
    localparam logic [ESC_W-1:0]        ESC_RSQ_RST  = 4'd4;

    // Fixed point: Q4.28 values, squares in Q8.56.
    localparam int FRAC_BITS = 28;

    // Colour scale: u = rounds * 767 / limit, green = (u >> 1) & 0xff, blue = u & 0xff.
    localparam int U_W     = 10;
    localparam int U_SCALE = 767;
    localparam logic [U_W-1:0] U_MAX = 10'h2ff;

    // Result fields.
    localparam int OUT_COORD_W = 12;
    localparam int COLOR_W     = 8;
    localparam int OUT_ITER_W  = 10;
    localparam int OUT_TDATA_W = 56;

    typedef struct packed {
        logic capture;     // latch the pixel indexes
        logic c_mult;      // form index * step products
        logic c_add;       // form c, clear z and the round counter
        logic z_mult;      // square and cross products of z
        logic z_step;      // z = z*z + c, count the round
        logic end_escape;  // pixel escaped at the previous round
        logic end_limit;   // round limit reached
        logic div_start;   // start the colour scale division
        logic out_load;    // load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic escape;      // |z|^2 above the bound after a round
        logic at_limit;    // round counter equals the limit
        logic black;       // pixel is drawn black
        logic limit_zero;  // limit of zero rounds
        logic div_done;    // division finished
    } dp_status_t;

endpackage

// ===== rtl/mandelbrot_pixel_colorizer_top.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_pixel_colorizer_top
// Escape-time colouring of one pixel per request, in Q4.28 fixed point.
// ----------------------------------------------------------------------------
// Usage: each request on the slave stream names a pixel by column and row.
// The block forms c from the configured origin and steps, iterates
// z = z*z + c and returns one result request on the master stream with the
// pixel indexes, the green and blue channels, the round count and, in tuser,
// a flag for pixels drawn black.
// One pixel is worked on at a time. Each round has one step for the three
// products of z and one for the update and the escape test. The colour scale
// division is skipped for black pixels and for a limit of zero rounds. The
// default limit is 64 rounds.
// The next request is taken in the cycle after the result register is loaded.
// The result waits in an output register, so the next request is taken while
// the receiver stalls; that next pixel then holds in its last state until the
// register is free.
// Reset restores the default view and limits and empties the block.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data while
// no pixel is in flight; the user must keep to this, the block does not enforce it.
// ----------------------------------------------------------------------------
module mandelbrot_pixel_colorizer_top #(
    parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = mpc_pkg::ITER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [mpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mpc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // column, row
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_column, out_row, green, blue, iterations
    output logic [mpc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // inside_res
    output logic                               m_axis_tuser
);

    localparam int PAD_W = mpc_pkg::OUT_TDATA_W - 2 * mpc_pkg::OUT_COORD_W
                           - 2 * mpc_pkg::COLOR_W - mpc_pkg::OUT_ITER_W;

    logic signed [mpc_pkg::CFG_W-1:0] start_re_reg, start_im_reg;
    logic signed [mpc_pkg::CFG_W-1:0] step_re_reg, step_im_reg;
    logic [mpc_pkg::MAX_ITER_W-1:0]   max_iter_reg;
    logic [mpc_pkg::ESC_W-1:0]        esc_rsq_reg;

    mpc_pkg::ctrl_cmd_t  cmd;
    mpc_pkg::dp_status_t status;

    logic [mpc_pkg::OUT_COORD_W-1:0] out_column, out_row;
    logic [mpc_pkg::COLOR_W-1:0]     green, blue;
    logic                            inside_res;
    logic [mpc_pkg::OUT_ITER_W-1:0]  iterations;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_re_reg <= mpc_pkg::START_RE_RST;
            start_im_reg <= mpc_pkg::START_IM_RST;
            step_re_reg  <= mpc_pkg::STEP_RE_RST;
            step_im_reg  <= mpc_pkg::STEP_IM_RST;
            max_iter_reg <= mpc_pkg::MAX_ITER_RST;
            esc_rsq_reg  <= mpc_pkg::ESC_RSQ_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mpc_pkg::CFG_START_RE: start_re_reg <= cfg_data;
                mpc_pkg::CFG_START_IM: start_im_reg <= cfg_data;
                mpc_pkg::CFG_STEP_RE:  step_re_reg  <= cfg_data;
                mpc_pkg::CFG_STEP_IM:  step_im_reg  <= cfg_data;
                mpc_pkg::CFG_MAX_ITER:
                    max_iter_reg <= cfg_data[mpc_pkg::MAX_ITER_W-1:0];
                mpc_pkg::CFG_ESC_RSQ:
                    esc_rsq_reg <= cfg_data[mpc_pkg::ESC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    mpc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    mpc_datapath #(
        .COORD_BITS (COORD_BITS),
        .ITER_BITS  (ITER_BITS)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .start_re         (start_re_reg),
        .start_im         (start_im_reg),
        .step_re          (step_re_reg),
        .step_im          (step_im_reg),
        .max_iter         (max_iter_reg),
        .escape_radius_sq (esc_rsq_reg),
        .column           (s_axis_tdata[COORD_BITS-1:0]),
        .row              (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .out_column       (out_column),
        .out_row          (out_row),
        .green            (green),
        .blue             (blue),
        .inside_res       (inside_res),
        .iterations       (iterations)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, iterations, blue, green, out_row, out_column};
    assign m_axis_tuser = inside_res;

endmodule

// ===== rtl/mpc_divider.sv =====
// ----------------------------------------------------------------------------
// mpc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpc_divider #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quot_reg, quot_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    // The quotient register holds the remaining dividend bits in its top end
    // and collects quotient bits at the bottom.
    assign trial = {rem_reg, quot_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, den};
    assign fits  = trial >= {1'b0, den};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (start)
        begin
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
            rem_next  = '0;
            quot_next = num;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quot_next = {quot_reg[NUM_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/mpc_datapath.sv =====
// ----------------------------------------------------------------------------
// mpc_datapath
// Point formation, the z = z*z + c iteration with its escape test, the colour
// scale division and the result register.
// ----------------------------------------------------------------------------
module mpc_datapath #(
    parameter int COORD_BITS = mpc_pkg::COORD_BITS_DEF,
    parameter int ITER_BITS  = mpc_pkg::ITER_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  mpc_pkg::ctrl_cmd_t                 cmd,
    output mpc_pkg::dp_status_t                status,
    input  logic signed [mpc_pkg::CFG_W-1:0]   start_re,
    input  logic signed [mpc_pkg::CFG_W-1:0]   start_im,
    input  logic signed [mpc_pkg::CFG_W-1:0]   step_re,
    input  logic signed [mpc_pkg::CFG_W-1:0]   step_im,
    input  logic [mpc_pkg::MAX_ITER_W-1:0]     max_iter,
    input  logic [mpc_pkg::ESC_W-1:0]          escape_radius_sq,
    input  logic [COORD_BITS-1:0]              column,
    input  logic [COORD_BITS-1:0]              row,
    output logic [mpc_pkg::OUT_COORD_W-1:0]    out_column,
    output logic [mpc_pkg::OUT_COORD_W-1:0]    out_row,
    output logic [mpc_pkg::COLOR_W-1:0]        green,
    output logic [mpc_pkg::COLOR_W-1:0]        blue,
    output logic                               inside_res,
    output logic [mpc_pkg::OUT_ITER_W-1:0]     iterations
);

    localparam int PROD_W = COORD_BITS + 33;
    localparam int NUM_W  = ITER_BITS + mpc_pkg::U_W;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = 32'sh7fffffff;
        else if (v < SAT_LO)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

    logic [COORD_BITS-1:0]      col_reg, row_reg;
    logic signed [PROD_W-1:0]   prod_re_reg, prod_im_reg;
    logic signed [31:0]         cr_reg, ci_reg, zr_reg, zi_reg;
    logic signed [63:0]         rr_reg, ii_reg, ri_reg;
    logic [ITER_BITS-1:0]       cnt_reg, rounds_reg;
    logic                       black_reg;
    logic [ITER_BITS-1:0]       limit;
    logic [63:0]                mag;
    logic [63:0]                bound;
    logic signed [63:0]         diff;
    logic signed [63:0]         nr_wide, ni_wide;
    logic signed [63:0]         cr_wide, ci_wide;
    logic                       z_zero;
    logic                       div_done;
    logic [NUM_W-1:0]           div_num;
    logic [NUM_W-1:0]           div_quot;
    logic [mpc_pkg::U_W-1:0]    u;

    logic [mpc_pkg::OUT_COORD_W-1:0] out_column_reg, out_row_reg;
    logic [mpc_pkg::COLOR_W-1:0]     green_reg, blue_reg;
    logic                            inside_res_reg;
    logic [mpc_pkg::OUT_ITER_W-1:0]  iterations_reg;

    assign limit = ITER_BITS'(max_iter);

    // The squares of the new z are formed at the start of the next round, so
    // the escape test for a round runs one multiply step after its update.
    assign mag    = $unsigned(rr_reg) + $unsigned(ii_reg);
    assign bound  = 64'(escape_radius_sq) << (2 * mpc_pkg::FRAC_BITS);
    assign diff   = rr_reg - ii_reg;
    assign nr_wide = (diff >>> mpc_pkg::FRAC_BITS) + 64'(cr_reg);
    assign ni_wide = (ri_reg >>> (mpc_pkg::FRAC_BITS - 1)) + 64'(ci_reg);
    assign cr_wide = 64'(start_re) + 64'(prod_re_reg);
    assign ci_wide = 64'(start_im) + 64'(prod_im_reg);
    assign z_zero  = (zr_reg == 32'sd0) && (zi_reg == 32'sd0);

    assign status.escape     = (cnt_reg != '0) && (mag > bound);
    assign status.at_limit   = cnt_reg == limit;
    assign status.black      = black_reg;
    assign status.limit_zero = limit == '0;
    assign status.div_done   = div_done;

    assign div_num = NUM_W'(rounds_reg) * NUM_W'(mpc_pkg::U_SCALE);

    mpc_divider #(
        .NUM_W (NUM_W),
        .DEN_W (ITER_BITS)
    ) u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (limit),
        .done  (div_done),
        .quot  (div_quot)
    );

    // The quotient never exceeds the scale, so its low bits carry u whole.
    assign u = (limit == '0) ? mpc_pkg::U_MAX : mpc_pkg::U_W'(div_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            black_reg <= 1'b0;
        end
        else
        begin
            if (cmd.c_add)
                cnt_reg <= '0;
            else if (cmd.z_step)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.end_escape)
                black_reg <= 1'b0;
            else if (cmd.end_limit)
                black_reg <= !z_zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            col_reg <= column;
            row_reg <= row;
        end
        if (cmd.c_mult)
        begin
            prod_re_reg <= PROD_W'($signed({1'b0, col_reg})) * PROD_W'(step_re);
            prod_im_reg <= PROD_W'($signed({1'b0, row_reg})) * PROD_W'(step_im);
        end
        if (cmd.c_add)
        begin
            cr_reg <= sat32(cr_wide);
            ci_reg <= sat32(ci_wide);
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (cmd.z_step)
        begin
            zr_reg <= sat32(nr_wide);
            zi_reg <= sat32(ni_wide);
        end
        if (cmd.z_mult)
        begin
            rr_reg <= 64'(zr_reg) * 64'(zr_reg);
            ii_reg <= 64'(zi_reg) * 64'(zi_reg);
            ri_reg <= 64'(zr_reg) * 64'(zi_reg);
        end
        if (cmd.end_escape)
            rounds_reg <= cnt_reg - 1'b1;
        else if (cmd.end_limit)
            rounds_reg <= limit;
        if (cmd.out_load)
        begin
            out_column_reg <= mpc_pkg::OUT_COORD_W'(col_reg);
            out_row_reg    <= mpc_pkg::OUT_COORD_W'(row_reg);
            green_reg      <= black_reg ? '0 : u[mpc_pkg::COLOR_W:1];
            blue_reg       <= black_reg ? '0 : u[mpc_pkg::COLOR_W-1:0];
            inside_res_reg <= black_reg;
            iterations_reg <= mpc_pkg::OUT_ITER_W'(rounds_reg);
        end
    end

    assign out_column = out_column_reg;
    assign out_row    = out_row_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign inside_res = inside_res_reg;
    assign iterations = iterations_reg;

endmodule

// ===== rtl/mpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpc_ctrl
// Sequencer for one pixel at a time, plus the valid flag of the result
// register.
// ----------------------------------------------------------------------------
module mpc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output mpc_pkg::ctrl_cmd_t  cmd,
    input  mpc_pkg::dp_status_t status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CMUL = 3'd1;
    localparam logic [2:0] S_CADD = 3'd2;
    localparam logic [2:0] S_ZMUL = 3'd3;
    localparam logic [2:0] S_ZUPD = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CMUL;
                end
            end
            S_CMUL:
            begin
                cmd.c_mult = 1'b1;
                state_next = S_CADD;
            end
            S_CADD:
            begin
                cmd.c_add  = 1'b1;
                state_next = S_ZMUL;
            end
            S_ZMUL:
            begin
                cmd.z_mult = 1'b1;
                state_next = S_ZUPD;
            end
            S_ZUPD:
            begin
                // Escape of the last round takes precedence over the limit.
                if (status.escape)
                begin
                    cmd.end_escape = 1'b1;
                    state_next     = S_FIN;
                end
                else if (status.at_limit)
                begin
                    cmd.end_limit = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    cmd.z_step = 1'b1;
                    state_next = S_ZMUL;
                end
            end
            S_FIN:
            begin
                if (status.black || status.limit_zero)
                    state_next = S_OUT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/mpc_checker.sv =====
// ----------------------------------------------------------------------------
// mpc_checker
// Port-level checks of the colouriser, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mpc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mpc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result request withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // Only one pixel is in flight: taking a request closes the input.
    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while a pixel is in work");

    // A pixel drawn black has both colour channels at zero.
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[39:24] == 16'd0)
        else $error("black pixel carries colour");

    // Green is the colour scale halved, blue its low byte: they share bits.
    a_colour: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[30:24] == m_axis_tdata[39:33])
        else $error("green and blue do not come from one scale value");

endmodule

bind mandelbrot_pixel_colorizer_top mpc_checker u_mpc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
